/* sv/mssc_pkg.sv */
`timescale 1ns / 1ps
package mssc_pkg;
  localparam int MemWordsDefault = 16384;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_MREAD = 2'd2;
  localparam logic [1:0] KIND_RREAD = 2'd3;

  localparam logic [2:0] CAUSE_NONE = 3'd0;
  localparam logic [2:0] CAUSE_FETCH = 3'd1;
  localparam logic [2:0] CAUSE_OPCODE = 3'd2;
  localparam logic [2:0] CAUSE_FUNCT = 3'd3;
  localparam logic [2:0] CAUSE_DATA = 3'd4;

  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J = 6'd2;
  localparam logic [5:0] OP_BEQ = 6'd4;
  localparam logic [5:0] OP_ADDI = 6'd8;
  localparam logic [5:0] OP_SLTI = 6'd10;
  localparam logic [5:0] OP_SLTIU = 6'd11;
  localparam logic [5:0] OP_LUI = 6'd15;
  localparam logic [5:0] OP_LW = 6'd35;
  localparam logic [5:0] OP_SW = 6'd43;

  localparam logic [5:0] FN_SHL16 = 6'd0;
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR = 6'd37;
  localparam logic [5:0] FN_NOR = 6'd39;
  localparam logic [5:0] FN_SLT = 6'd42;
  localparam logic [5:0] FN_SLTU = 6'd43;

  typedef struct packed {
    logic [1:0] kind;
    logic [13:0] word_index;
    logic [4:0] reg_index;
    logic [31:0] data;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pc;
    logic halted;
    logic [2:0] halt_cause;
    logic [31:0] read_data;
    logic [31:0] instruction;
  } out_item_t;
endpackage

/* sv/mssc_if.sv */
`timescale 1ns / 1ps
interface mssc_in_if;
  logic valid;
  logic ready;
  mssc_pkg::in_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface mssc_out_if;
  logic valid;
  logic ready;
  mssc_pkg::out_item_t payload;
  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

/* sv/mips_subset_single_cycle_core_unit.sv */
`timescale 1ns / 1ps
// channel | dir | payload
// in_ch   | in  | kind, word_index, reg_index, data
// out_ch  | out | pc, halted, halt_cause, read_data, instruction
// cfg     | in  | cfg_we, cfg_data (start_pc)
// A transaction: the accept cycle issues the memory read (fetch or
// word read), the next cycle executes and loads the output register.
// lw adds the ST_LW state for its data read and register write-back.
// Input is taken only in the idle state, so a new item is not accepted until the last one is through.
// After reset, a clearing pass over all MEM_WORDS words zeroes memory; no input taken.
// Output register with a one-deep stall: input accepted while output is empty
// or being taken.
module mips_subset_single_cycle_core_unit #(
  parameter int MEM_WORDS = mssc_pkg::MemWordsDefault
) (
  input logic clk,
  input logic rst,
  mssc_in_if.sink in_ch,
  mssc_out_if.source out_ch,
  input logic cfg_we,
  input logic [15:0] cfg_data
);
  localparam int Aw = $clog2(MEM_WORDS);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_LW = 2'd2;

  logic [1:0] st;
  logic [31:0] pc;
  logic halted;
  logic [2:0] cause;
  mssc_pkg::in_item_t cur;
  logic [31:0] ins;
  logic [4:0] lw_rt;
  logic out_v;
  mssc_pkg::out_item_t out_q;

  logic [Aw-1:0] raddr, waddr;
  logic [31:0] rdata, wdata;
  logic mwe, clr_busy;
  logic [31:0] da, db, rwd;
  logic rwe;
  logic [4:0] rwa;
  logic [4:0] rwa_sel;
  // step_live: step accepted while running with good fetch
  logic step_live;
  logic live_q;

  mssc_mem #(.Words(MEM_WORDS), .Aw(Aw)) u_mem (
    .clk, .rst, .raddr, .rdata, .we(mwe), .waddr, .wdata, .clr_busy
  );

  logic [5:0] op, fn;
  logic [4:0] rs, rt, rd;
  logic [31:0] ext;
  assign op = ins[31:26];
  assign rs = ins[25:21];
  assign rt = ins[20:16];
  assign rd = ins[15:11];
  assign fn = ins[5:0];
  assign ext = {{16{ins[15]}}, ins[15:0]};

  mssc_regfile u_rf (
    .clk, .rst, .ra(step_live ? rs : cur.reg_index), .rb(rt), .da, .db,
    .we(rwe), .wa(rwa_sel), .wd(rwd)
  );

  logic can_take, fin, accept;
  assign can_take = !out_v || out_ch.ready;
  assign in_ch.ready = (st == ST_IDLE) && !clr_busy && can_take;
  assign accept = in_ch.valid && in_ch.ready;

  logic pc_ok;
  assign pc_ok = (pc[1:0] == 2'b00) && ((pc >> 2) < 32'(MEM_WORDS));
  logic [31:0] addr;
  logic addr_ok;
  assign addr = da + ext;
  assign addr_ok = (addr[1:0] == 2'b00) && ((addr >> 2) < 32'(MEM_WORDS));
  logic idx_ok;
  assign idx_ok = 32'(cur.word_index) < 32'(MEM_WORDS);
  logic in_idx_ok;
  assign in_idx_ok = 32'(in_ch.payload.word_index) < 32'(MEM_WORDS);

  // execute-stage decode
  logic [31:0] res, nxt, pc4;
  logic wr, bad_op, bad_fn, is_mem;
  assign pc4 = pc + 32'd4;
  always_comb begin
    res = '0; nxt = pc4; wr = 1'b0; bad_op = 1'b0; bad_fn = 1'b0; is_mem = 1'b0;
    rwa = rt;
    unique case (op)
      mssc_pkg::OP_RTYPE: begin
        rwa = rd; wr = 1'b1;
        unique case (fn)
          mssc_pkg::FN_SHL16: res = {db[15:0], 16'd0};
          mssc_pkg::FN_ADD: res = da + db;
          mssc_pkg::FN_SUB: res = da - db;
          mssc_pkg::FN_AND: res = da & db;
          mssc_pkg::FN_OR: res = da | db;
          mssc_pkg::FN_NOR: res = ~(da | db);
          mssc_pkg::FN_SLT: res = {31'd0, $signed(da) < $signed(db)};
          mssc_pkg::FN_SLTU: res = {31'd0, da < db};
          default: begin bad_fn = 1'b1; wr = 1'b0; end
        endcase
      end
      mssc_pkg::OP_J: nxt = {pc4[31:28], ins[25:0], 2'b00};
      mssc_pkg::OP_BEQ: if (da == db) nxt = pc4 + {ext[29:0], 2'b00};
      mssc_pkg::OP_ADDI: begin res = da + ext; wr = 1'b1; end
      mssc_pkg::OP_SLTI: begin res = {31'd0, $signed(da) < $signed(ext)}; wr = 1'b1; end
      mssc_pkg::OP_SLTIU: begin res = {31'd0, da < ext}; wr = 1'b1; end
      mssc_pkg::OP_LUI: begin res = {ext[15:0], 16'd0}; wr = 1'b1; end
      mssc_pkg::OP_LW, mssc_pkg::OP_SW: is_mem = 1'b1;
      default: bad_op = 1'b1;
    endcase
  end

  logic ex_ok;
  assign ex_ok = !bad_op && !bad_fn && !(is_mem && !addr_ok);

  logic do_lw, fault;
  logic [2:0] fault_cause;
  logic [31:0] rd_word;
  assign do_lw = step_live && ex_ok && (op == mssc_pkg::OP_LW);
  assign fault = step_live && !ex_ok;
  assign fault_cause = bad_op ? mssc_pkg::CAUSE_OPCODE :
                       bad_fn ? mssc_pkg::CAUSE_FUNCT : mssc_pkg::CAUSE_DATA;

  always_comb begin
    unique case (cur.kind)
      mssc_pkg::KIND_MREAD: rd_word = idx_ok ? rdata : '0;
      mssc_pkg::KIND_RREAD: rd_word = da;
      default: rd_word = '0;
    endcase
  end

  always_comb begin
    rwe = 1'b0; rwd = res;
    if (st == ST_EXEC && step_live && ex_ok && wr) rwe = 1'b1;
    if (st == ST_LW) begin rwe = 1'b1; rwd = rdata; end
  end

  // lw write-back uses its saved target
  always_comb begin
    rwa_sel = (st == ST_LW) ? lw_rt : rwa;
  end

  always_comb begin
    raddr = in_ch.payload.word_index[Aw-1:0];
    if (in_ch.payload.kind == mssc_pkg::KIND_STEP) raddr = pc[Aw+1:2];
    if (st == ST_EXEC) raddr = addr[Aw+1:2];
    mwe = 1'b0; waddr = in_ch.payload.word_index[Aw-1:0];
    wdata = in_ch.payload.data;
    if (accept && in_ch.payload.kind == mssc_pkg::KIND_LOAD && in_idx_ok) mwe = 1'b1;
    if (st == ST_EXEC && step_live && ex_ok && op == mssc_pkg::OP_SW) begin
      mwe = 1'b1; waddr = addr[Aw+1:2]; wdata = db;
    end
  end

  assign out_ch.valid = out_v;
  assign out_ch.payload = out_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE; pc <= '0; halted <= 1'b0; cause <= mssc_pkg::CAUSE_NONE;
      out_v <= 1'b0;
    end else begin
      if (out_v && out_ch.ready) out_v <= 1'b0;
      if (cfg_we) pc <= {16'd0, cfg_data};
      unique case (st)
        ST_IDLE: if (accept) begin
          cur <= in_ch.payload;
          st <= ST_EXEC;
          if (in_ch.payload.kind == mssc_pkg::KIND_STEP && !halted && !pc_ok) begin
            halted <= 1'b1; cause <= mssc_pkg::CAUSE_FETCH;
          end
        end
        ST_EXEC: begin
          // ins is valid here only for live steps
          out_q.read_data <= rd_word;
          out_q.instruction <= step_live ? ins : '0;
          out_q.pc <= (step_live && ex_ok) ? nxt : pc;
          out_q.halted <= halted || fault;
          out_q.halt_cause <= fault ? fault_cause : cause;
          out_v <= !do_lw;
          st <= do_lw ? ST_LW : ST_IDLE;
          if (fault) begin
            halted <= 1'b1; cause <= fault_cause;
          end
          if (step_live && ex_ok) pc <= nxt;
        end
        ST_LW: begin
          st <= ST_IDLE; out_v <= 1'b1;
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) live_q <= 1'b0;
    else if (accept) live_q <= in_ch.payload.kind == mssc_pkg::KIND_STEP && !halted && pc_ok;
  end
  assign step_live = live_q;
  assign ins = rdata;
  always_ff @(posedge clk) begin
    if (st == ST_EXEC) lw_rt <= rt;
  end

  assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt not sticky");
  assert property (@(posedge clk) disable iff (rst) (st == ST_LW) |=> out_v)
    else $error("lw result lost");
  assert property (@(posedge clk) disable iff (rst) accept |-> !clr_busy)
    else $error("accept during clear");
endmodule

/* sv/mssc_mem.sv */
`timescale 1ns / 1ps
module mssc_mem #(
  parameter int Words = mssc_pkg::MemWordsDefault,
  parameter int Aw = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic [Aw-1:0] raddr,
  output logic [31:0] rdata,
  input  logic we,
  input  logic [Aw-1:0] waddr,
  input  logic [31:0] wdata,
  output logic clr_busy
);
  logic [31:0] mem [Words];
  logic [Aw:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clr_busy) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end
  assign clr_busy = (clr_cnt < (Aw+1)'(Words));

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem[clr_cnt[Aw-1:0]] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* sv/mssc_regfile.sv */
`timescale 1ns / 1ps
module mssc_regfile (
  input  logic clk,
  input  logic rst,
  input  logic [4:0] ra,
  input  logic [4:0] rb,
  output logic [31:0] da,
  output logic [31:0] db,
  input  logic we,
  input  logic [4:0] wa,
  input  logic [31:0] wd
);
  // flip-flop file, valid bits give zero after reset
  logic [31:0] rf [32];
  logic [31:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[wa] <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (we) rf[wa] <= wd;
  end
  assign da = vld[ra] ? rf[ra] : '0;
  assign db = vld[rb] ? rf[rb] : '0;
endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
  localparam int MEM = mssc_pkg::MemWordsDefault;
  localparam int LIMIT = 1500000;
  localparam int PHASE_ITEMS = 480;

  // Tracks architectural state of the core and the queue of results still owed.
  class core_scoreboard;
    logic [31:0] mem[MEM];
    logic [31:0] regs[32];
    logic [31:0] pc;
    logic halted;
    logic [2:0] cause;
    mssc_pkg::out_item_t owed_q[$];
    int errors;

    function void clear();
      foreach (mem[i]) mem[i] = '0;
      foreach (regs[i]) regs[i] = '0;
      pc = '0;
      halted = 1'b0;
      cause = mssc_pkg::CAUSE_NONE;
      errors = 0;
    endfunction

    function void load_pc(logic [15:0] v);
      pc = {16'h0, v};
    endfunction

    function void stop_core(logic [2:0] c);
      halted = 1'b1;
      cause = c;
    endfunction

    // Returns the fetched word, zero on a bad fetch.
    function logic [31:0] run_instr();
      logic [31:0] ins, a, b, ext, res, nxt, addr;
      logic [5:0] op, fn;
      logic [4:0] dest;
      bit wr;
      if (pc[1:0] != 2'b00 || pc[31:16] != 16'h0) begin
        stop_core(mssc_pkg::CAUSE_FETCH);
        return '0;
      end
      ins = mem[pc[15:2]];
      op = ins[31:26];
      fn = ins[5:0];
      ext = {{16{ins[15]}}, ins[15:0]};
      a = regs[ins[25:21]];
      b = regs[ins[20:16]];
      nxt = pc + 32'd4;
      res = '0;
      dest = ins[20:16];
      wr = 1'b1;
      case (op)
        mssc_pkg::OP_RTYPE: begin
          case (fn)
            mssc_pkg::FN_SHL16: res = b << 16;
            mssc_pkg::FN_ADD: res = a + b;
            mssc_pkg::FN_SUB: res = a - b;
            mssc_pkg::FN_AND: res = a & b;
            mssc_pkg::FN_OR: res = a | b;
            mssc_pkg::FN_NOR: res = ~(a | b);
            mssc_pkg::FN_SLT: res = {31'b0, $signed(a) < $signed(b)};
            mssc_pkg::FN_SLTU: res = {31'b0, a < b};
            default: begin
              stop_core(mssc_pkg::CAUSE_FUNCT);
              return ins;
            end
          endcase
          dest = ins[15:11];
        end
        mssc_pkg::OP_J: begin
          nxt = {nxt[31:28], ins[25:0], 2'b00};
          wr = 1'b0;
        end
        mssc_pkg::OP_BEQ: begin
          if (a == b) nxt = nxt + (ext << 2);
          wr = 1'b0;
        end
        mssc_pkg::OP_ADDI: res = a + ext;
        mssc_pkg::OP_SLTI: res = {31'b0, $signed(a) < $signed(ext)};
        mssc_pkg::OP_SLTIU: res = {31'b0, a < ext};
        mssc_pkg::OP_LUI: res = ext << 16;
        mssc_pkg::OP_LW, mssc_pkg::OP_SW: begin
          addr = a + ext;
          if (addr[1:0] != 2'b00 || addr[31:16] != 16'h0) begin
            stop_core(mssc_pkg::CAUSE_DATA);
            return ins;
          end
          if (op == mssc_pkg::OP_LW) res = mem[addr[15:2]];
          else begin
            mem[addr[15:2]] = b;
            wr = 1'b0;
          end
        end
        default: begin
          stop_core(mssc_pkg::CAUSE_OPCODE);
          return ins;
        end
      endcase
      if (wr) regs[dest] = res;
      pc = nxt;
      return ins;
    endfunction

    function void note(mssc_pkg::in_item_t it);
      mssc_pkg::out_item_t o;
      o = '0;
      case (it.kind)
        mssc_pkg::KIND_LOAD: mem[it.word_index] = it.data;
        mssc_pkg::KIND_STEP: if (!halted) o.instruction = run_instr();
        mssc_pkg::KIND_MREAD: o.read_data = mem[it.word_index];
        default: o.read_data = regs[it.reg_index];
      endcase
      o.pc = pc;
      o.halted = halted;
      o.halt_cause = cause;
      owed_q.push_back(o);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check(mssc_pkg::out_item_t got);
      mssc_pkg::out_item_t w;
      if (owed_q.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      w = owed_q.pop_front();
      if (got.pc !== w.pc) report($sformatf("pc %h, want %h", got.pc, w.pc));
      if (got.halted !== w.halted)
        report($sformatf("halted %b, want %b", got.halted, w.halted));
      if (got.halt_cause !== w.halt_cause)
        report($sformatf("halt_cause %0d, want %0d", got.halt_cause, w.halt_cause));
      if (got.read_data !== w.read_data)
        report($sformatf("read_data %h, want %h", got.read_data, w.read_data));
      if (got.instruction !== w.instruction)
        report($sformatf("instruction %h, want %h", got.instruction, w.instruction));
    endtask
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [15:0] cfg_data;
  mssc_in_if in_ch();
  mssc_out_if out_ch();

  core_scoreboard sb;
  int cycles;
  int sent;
  bit calm;
  bit hold_req;
  int hold_left;
  int stall_left;

  logic [5:0] op_list[8] = '{mssc_pkg::OP_RTYPE, mssc_pkg::OP_J, mssc_pkg::OP_BEQ,
                             mssc_pkg::OP_ADDI, mssc_pkg::OP_SLTI, mssc_pkg::OP_SLTIU,
                             mssc_pkg::OP_LUI, mssc_pkg::OP_LW};
  logic [5:0] fn_list[8] = '{mssc_pkg::FN_SHL16, mssc_pkg::FN_ADD, mssc_pkg::FN_SUB,
                             mssc_pkg::FN_AND, mssc_pkg::FN_OR, mssc_pkg::FN_NOR,
                             mssc_pkg::FN_SLT, mssc_pkg::FN_SLTU};

  mips_subset_single_cycle_core_unit dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    wait (cycles >= LIMIT);
    $display("mips_subset_single_cycle_core_unit test failed");
    $finish;
  end

  // Result side: random stalls plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready = 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 300;
      out_ch.ready = 1'b0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      out_ch.ready = 1'b1;
      if (!calm && r >= 70) begin
        out_ch.ready = 1'b0;
        stall_left = (r < 96) ? $urandom_range(0, 2) : $urandom_range(20, 60);
      end
    end
  end

  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready) sb.check(out_ch.payload);
  end

  task send(mssc_pkg::in_item_t it);
    int r, g;
    r = $urandom_range(0, 99);
    g = 0;
    if (!calm) g = (r < 60) ? 0 : (r < 94) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (g) @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.payload = it;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(it);
    sent++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  // Unused fields carry random bits.
  task send_kind(logic [1:0] k, logic [13:0] widx, logic [4:0] ridx, logic [31:0] d);
    mssc_pkg::in_item_t it;
    it.word_index = 14'($urandom);
    it.reg_index = 5'($urandom);
    it.data = $urandom;
    it.kind = k;
    if (k == mssc_pkg::KIND_LOAD || k == mssc_pkg::KIND_MREAD) it.word_index = widx;
    if (k == mssc_pkg::KIND_RREAD) it.reg_index = ridx;
    if (k == mssc_pkg::KIND_LOAD) it.data = d;
    send(it);
  endtask

  // Places an instruction at the predicted PC, then executes it.
  task place_and_step(logic [31:0] ins);
    send_kind(mssc_pkg::KIND_LOAD, sb.pc[15:2], '0, ins);
    send_kind(mssc_pkg::KIND_STEP, '0, '0, '0);
  endtask

  // Keep sequential flow from running off the end of memory.
  task hop();
    if (sb.pc[15:2] == 14'h3FFF)
      place_and_step({mssc_pkg::OP_J, 12'h0, 14'($urandom_range(0, MEM - 2))});
  endtask

  task exec_op(logic [5:0] op, logic [5:0] fn);
    logic [4:0] rs, rt, rd;
    logic [15:0] imm;
    logic [31:0] tgt, diff;
    int off;
    hop();
    rs = 5'($urandom);
    rt = 5'($urandom);
    rd = 5'($urandom);
    imm = 16'($urandom);
    case (op)
      mssc_pkg::OP_RTYPE: place_and_step({op, rs, rt, rd, 5'($urandom), fn});
      mssc_pkg::OP_J: place_and_step({op, 12'h0, 14'($urandom_range(0, MEM - 1))});
      mssc_pkg::OP_BEQ: begin
        if ($urandom_range(0, 1)) rt = rs;
        off = int'($urandom_range(0, MEM - 1)) - (int'(sb.pc[15:2]) + 1);
        place_and_step({op, rs, rt, 16'(off)});
      end
      mssc_pkg::OP_LW, mssc_pkg::OP_SW: begin
        tgt = {16'h0, 14'($urandom_range(0, MEM - 1)), 2'b00};
        diff = tgt - sb.regs[rs];
        if (diff[31:15] == '0 || diff[31:15] == '1) imm = diff[15:0];
        else begin
          // base too far away: zero it first
          place_and_step({mssc_pkg::OP_LUI, 5'($urandom), rs, 16'h0});
          hop();
          imm = {1'b0, 13'($urandom), 2'b00};
        end
        place_and_step({op, rs, rt, imm});
      end
      default: place_and_step({op, rs, rt, imm});
    endcase
  endtask

  task noise();
    logic [1:0] k;
    logic [31:0] d;
    k = 2'($urandom_range(0, 2));
    if (k == 2'd1) k = mssc_pkg::KIND_RREAD;
    d = $urandom;
    if ($urandom_range(0, 9) == 0) d = $urandom_range(0, 1) ? '1 : '0;
    send_kind(k, 14'($urandom), 5'($urandom), d);
  endtask

  task drain();
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_start(logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 1'b0;
    cfg_data = 16'($urandom);
    sb.load_pc(v);
  endtask

  task random_phase();
    int stop_at;
    stop_at = sent + PHASE_ITEMS;
    while (sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 8) == 0) exec_op(mssc_pkg::OP_SW, '0);
        else exec_op(op_list[$urandom_range(0, 7)], fn_list[$urandom_range(0, 7)]);
      end else noise();
    end
  endtask

  task halt_phase();
    logic [5:0] op;
    logic [5:0] fn;
    logic [4:0] rs;
    logic [15:0] imm;
    case ($urandom_range(0, 3))
      0: begin
        write_start({14'($urandom_range(0, MEM - 1)), 2'($urandom_range(1, 3))});
        send_kind(mssc_pkg::KIND_STEP, '0, '0, '0);
      end
      1: begin
        hop();
        do op = 6'($urandom);
        while (op inside {mssc_pkg::OP_RTYPE, mssc_pkg::OP_J, mssc_pkg::OP_BEQ,
                          mssc_pkg::OP_ADDI, mssc_pkg::OP_SLTI, mssc_pkg::OP_SLTIU,
                          mssc_pkg::OP_LUI, mssc_pkg::OP_LW, mssc_pkg::OP_SW});
        place_and_step({op, 26'($urandom)});
      end
      2: begin
        hop();
        do fn = 6'($urandom);
        while (fn inside {mssc_pkg::FN_SHL16, mssc_pkg::FN_ADD, mssc_pkg::FN_SUB,
                          mssc_pkg::FN_AND, mssc_pkg::FN_OR, mssc_pkg::FN_NOR,
                          mssc_pkg::FN_SLT, mssc_pkg::FN_SLTU});
        place_and_step({mssc_pkg::OP_RTYPE, 20'($urandom), fn});
      end
      default: begin
        hop();
        rs = 5'($urandom);
        place_and_step({mssc_pkg::OP_LUI, 5'($urandom), rs, 16'h0});
        hop();
        imm = 16'($urandom);
        if (imm[1:0] == 2'b00) imm[15] = 1'b1;
        place_and_step({$urandom_range(0, 1) ? mssc_pkg::OP_LW : mssc_pkg::OP_SW,
                        rs, 5'($urandom), imm});
      end
    endcase
    // halted core: steps do nothing, loads and reads still work
    repeat (10) begin
      if ($urandom_range(0, 1)) exec_op(op_list[$urandom_range(0, 7)], mssc_pkg::FN_ADD);
      else noise();
    end
  endtask

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    cycles = 0;
    sent = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    stall_left = 0;
    sb = new();
    sb.clear();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: field extremes, then every opcode and funct
    send_kind(mssc_pkg::KIND_RREAD, '0, 5'd0, '0);
    send_kind(mssc_pkg::KIND_RREAD, '1, 5'd31, '0);
    send_kind(mssc_pkg::KIND_LOAD, 14'h3FFF, '0, '1);
    send_kind(mssc_pkg::KIND_MREAD, 14'h3FFF, '0, '0);
    send_kind(mssc_pkg::KIND_MREAD, 14'h0, '0, '0);
    foreach (fn_list[i]) exec_op(mssc_pkg::OP_RTYPE, fn_list[i]);
    for (int i = 1; i < 8; i++) exec_op(op_list[i], '0);
    exec_op(mssc_pkg::OP_SW, '0);
    send_kind(mssc_pkg::KIND_RREAD, '0, 5'd0, '0);

    write_start(16'hFFFC);
    calm = 1'b1;
    random_phase();
    calm = 1'b0;

    write_start(16'h0000);
    hold_req = 1'b1;
    random_phase();

    write_start({14'($urandom_range(0, MEM - 1)), 2'b00});
    random_phase();

    halt_phase();

    drain();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.owed_q.size() == 0)
      $display("mips_subset_single_cycle_core_unit test passed");
    else
      $display("mips_subset_single_cycle_core_unit test failed");
    $finish;
  end
endmodule

/* sim.f */
sv/mssc_pkg.sv
sv/mssc_if.sv
sv/mssc_mem.sv
sv/mssc_regfile.sv
sv/mips_subset_single_cycle_core_unit.sv
test/tb.sv
